>>> src/pvd_pkg.sv
package pvd_pkg;

  localparam int unsigned NUM_CLASSES = 9;

  localparam logic [3:0] CLASS_INVALID = 4'd9;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;

  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;
  localparam logic [1:0] WIDTH_64 = 2'd3;

  localparam logic [1:0] TWS_RESET = WIDTH_64;

  typedef logic [63:0] value_t;
  typedef logic [4:0]  len_t;
  typedef logic [1:0]  status_t;
  typedef logic [3:0]  class_t;

  typedef struct packed {
    value_t  value;
    len_t    code_length;
    status_t status;
  } result_t;

  function automatic class_t classify(input logic [7:0] b);
    class_t c;
    if (b[7] == 1'b0) begin
      c = 4'd0;
    end else if (b[7:6] == 2'b10) begin
      c = 4'd1;
    end else if (b[7:5] == 3'b110) begin
      c = 4'd2;
    end else if (b[7:3] == 5'b11100) begin
      c = 4'd3;
    end else if (b[7:3] == 5'b11101) begin
      c = 4'd4;
    end else if (b[7:3] == 5'b11110) begin
      c = 4'd5;
    end else if (b == 8'hf8) begin
      c = 4'd6;
    end else if (b == 8'hf9) begin
      c = 4'd7;
    end else if (b == 8'hfa) begin
      c = 4'd8;
    end else begin
      c = CLASS_INVALID;
    end
    return c;
  endfunction

  function automatic len_t class_bytes(input class_t c);
    len_t n;
    case (c)
      4'd0:    n = 5'd1;
      4'd1:    n = 5'd2;
      4'd2:    n = 5'd3;
      4'd3:    n = 5'd4;
      4'd4:    n = 5'd5;
      4'd5:    n = 5'd6;
      4'd6:    n = 5'd8;
      4'd7:    n = 5'd9;
      4'd8:    n = 5'd17;
      default: n = 5'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] class_payload_mask(input class_t c);
    logic [7:0] m;
    case (c)
      4'd0:    m = 8'h7f;
      4'd1:    m = 8'h3f;
      4'd2:    m = 8'h1f;
      4'd3:    m = 8'h07;
      4'd4:    m = 8'h07;
      4'd5:    m = 8'h07;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic class_t class_limit(input logic [1:0] sel);
    class_t l;
    case (sel)
      WIDTH_8:  l = 4'd1;
      WIDTH_16: l = 4'd2;
      WIDTH_32: l = 4'd3;
      default:  l = 4'd7;
    endcase
    return l;
  endfunction

  function automatic logic value_over(input logic [1:0] sel, input value_t v);
    logic o;
    case (sel)
      WIDTH_8:  o = |v[63:8];
      WIDTH_16: o = |v[63:16];
      WIDTH_32: o = |v[63:32];
      default:  o = 1'b0;
    endcase
    return o;
  endfunction

endpackage

>>> src/pvd_if.sv
interface pvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface pvd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [4:0]  code_length;
  logic [1:0]  status;

  modport source (output valid, output value, output code_length, output status, input ready);
  modport sink (input valid, input value, input code_length, input status, output ready);
endinterface

interface pvd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] target_width_select;

  modport source (output valid, output target_width_select, input ready);
  modport sink (input valid, input target_width_select, output ready);
endinterface

>>> src/prefix_varint_stream_decoder_core.sv
// Prefix-length varint stream decoder.
// in_ch carries one byte of the coded stream per word; out_ch carries one
// result word (value, code_length, status) for each complete code, and one
// at once for an invalid first byte (0xfb..0xff). cfg_ch writes the target
// width select (0=8, 1=16, 2=32, 3=64 bits), always ready; the user must
// write it only while no code is in progress; the block does not enforce
// this. Throughput: one byte per cycle barring stalls. The result word is on
// out_ch in the cycle after the last byte is taken. The decode of a byte is a
// single combinational pass from the state registers to the result register.
// Reset: awaits a first byte, no result pending, target width 64 bits.
// A stalled receiver holds the result register; in_ch stays ready as long
// as the result register is empty or is taken in the same cycle, so a byte
// that finishes no code is taken even while a result waits.
module prefix_varint_stream_decoder_core (
  input  logic              clk,
  input  logic              rst_n,
  pvd_in_if.sink            in_ch,
  pvd_out_if.source         out_ch,
  pvd_cfg_if.sink           cfg_ch
);
  import pvd_pkg::*;

  logic [4:0]  bytes_left_r, bytes_left_nxt;
  value_t      acc_r, acc_nxt;
  class_t      class_r, class_nxt;
  logic        hbs_r, hbs_nxt;
  logic [1:0]  tws_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res_nxt;

  logic        in_ready;
  logic        in_take;
  logic        emit;
  class_t      first_class;

  assign first_class = classify(in_ch.in_byte);
  assign emit        = (bytes_left_r == 5'd0 && first_class == CLASS_INVALID) ||
                       (bytes_left_nxt == 5'd0);
  assign in_ready    = !out_valid_r || out_ch.ready || !emit;
  assign in_take     = in_ch.valid && in_ready;

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    acc_nxt        = acc_r;
    class_nxt      = class_r;
    hbs_nxt        = hbs_r;
    res_nxt        = res_r;
    if (bytes_left_r == 5'd0) begin
      if (first_class != CLASS_INVALID) begin
        class_nxt      = first_class;
        acc_nxt        = {56'd0, in_ch.in_byte & class_payload_mask(first_class)};
        hbs_nxt        = 1'b0;
        bytes_left_nxt = class_bytes(first_class) - 5'd1;
      end
    end else begin
      hbs_nxt        = hbs_r || (acc_r[63:56] != 8'd0);
      acc_nxt        = {acc_r[55:0], in_ch.in_byte};
      bytes_left_nxt = bytes_left_r - 5'd1;
    end
    if (bytes_left_r == 5'd0 && first_class == CLASS_INVALID) begin
      res_nxt.value       = '0;
      res_nxt.code_length = 5'd1;
      res_nxt.status      = STATUS_INVALID;
    end else begin
      res_nxt.value       = acc_nxt;
      res_nxt.code_length = class_bytes(class_nxt);
      if (class_nxt > class_limit(tws_r) || hbs_nxt || value_over(tws_r, acc_nxt)) begin
        res_nxt.status = STATUS_RANGE;
      end else begin
        res_nxt.status = STATUS_OK;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (in_take && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 5'd0;
      acc_r        <= '0;
      class_r      <= 4'd0;
      hbs_r        <= 1'b0;
      tws_r        <= TWS_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_take) begin
        bytes_left_r <= bytes_left_nxt;
        acc_r        <= acc_nxt;
        class_r      <= class_nxt;
        hbs_r        <= hbs_nxt;
      end
      if (cfg_ch.valid) begin
        tws_r <= cfg_ch.target_width_select;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && emit) begin
      res_r <= res_nxt;
    end
  end

  assign in_ch.ready        = in_ready;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.value       = res_r.value;
  assign out_ch.code_length = res_r.code_length;
  assign out_ch.status      = res_r.status;

endmodule

>>> sim/pvd_decode_checker.sv
`timescale 1ns / 1ps
module pvd_decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  pvd_in_if           in_ch,
  pvd_out_if          out_ch,
  pvd_cfg_if          cfg_ch,
  output int unsigned faults,
  output int unsigned pending,
  output logic        code_open
);
  import pvd_pkg::*;

  result_t    due_results[$];
  logic [1:0] width_sel;
  len_t       bytes_due;
  value_t     gathered;
  class_t     cur_class;
  logic       overflowed;

  function automatic class_t lead_class(input logic [7:0] b);
    class_t c;
    casez (b)
      8'b0???????: c = 4'd0;
      8'b10??????: c = 4'd1;
      8'b110?????: c = 4'd2;
      8'b11100???: c = 4'd3;
      8'b11101???: c = 4'd4;
      8'b11110???: c = 4'd5;
      8'hf8:       c = 4'd6;
      8'hf9:       c = 4'd7;
      8'hfa:       c = 4'd8;
      default:     c = CLASS_INVALID;
    endcase
    return c;
  endfunction

  function automatic len_t span_of(input class_t c);
    len_t n;
    case (c)
      4'd6:    n = 5'd8;
      4'd7:    n = 5'd9;
      4'd8:    n = 5'd17;
      default: n = len_t'(c) + 5'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] free_mask(input class_t c);
    int unsigned lead_bits;
    case (c)
      4'd0:       lead_bits = 1;
      4'd1:       lead_bits = 2;
      4'd2:       lead_bits = 3;
      4'd3, 4'd4,
      4'd5:       lead_bits = 5;
      default:    lead_bits = 8;
    endcase
    return 8'hff >> lead_bits;
  endfunction

  function automatic class_t class_cap(input logic [1:0] sel);
    class_t c;
    case (sel)
      WIDTH_8:  c = 4'd1;
      WIDTH_16: c = 4'd2;
      WIDTH_32: c = 4'd3;
      default:  c = 4'd7;
    endcase
    return c;
  endfunction

  function automatic value_t value_cap(input logic [1:0] sel);
    value_t v;
    case (sel)
      WIDTH_8:  v = 64'h0000_0000_0000_00ff;
      WIDTH_16: v = 64'h0000_0000_0000_ffff;
      WIDTH_32: v = 64'h0000_0000_ffff_ffff;
      default:  v = '1;
    endcase
    return v;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    class_t  c;
    result_t r;
    if (bytes_due == '0) begin
      c = lead_class(b);
      if (c == CLASS_INVALID) begin
        r.value       = '0;
        r.code_length = 5'd1;
        r.status      = STATUS_INVALID;
        due_results   = {due_results, r};
        return;
      end
      cur_class  = c;
      gathered   = value_t'(b & free_mask(c));
      overflowed = 1'b0;
      bytes_due  = span_of(c) - 5'd1;
    end else begin
      if (gathered[63:56] != 8'h00) overflowed = 1'b1;
      gathered  = {gathered[55:0], b};
      bytes_due = bytes_due - 5'd1;
    end
    if (bytes_due == '0) begin
      r.value       = gathered;
      r.code_length = span_of(cur_class);
      if (cur_class > class_cap(width_sel) || overflowed || gathered > value_cap(width_sel))
        r.status = STATUS_RANGE;
      else
        r.status = STATUS_OK;
      due_results = {due_results, r};
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      faults++;
      if (faults <= 10)
        $display("%0t: unexpected result word value %h length %0d status %0d",
                 $realtime, got.value, got.code_length, got.status);
      return;
    end
    want = due_results.pop_front();
    if (got.value !== want.value || got.code_length !== want.code_length ||
        got.status !== want.status) begin
      faults++;
      if (faults <= 10)
        $display("%0t: result mismatch: expected %h/%0d/%0d, got %h/%0d/%0d", $realtime,
                 want.value, want.code_length, want.status,
                 got.value, got.code_length, got.status);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    if (!rst_n) begin
      due_results.delete();
      width_sel  = TWS_RESET;
      bytes_due  = '0;
      gathered   = '0;
      cur_class  = '0;
      overflowed = 1'b0;
      faults     = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.value       = out_ch.value;
        got.code_length = out_ch.code_length;
        got.status      = out_ch.status;
        check_result(got);
      end
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.in_byte);
      if (cfg_ch.valid && cfg_ch.ready) width_sel = cfg_ch.target_width_select;
    end
    pending   = due_results.size();
    code_open = (bytes_due != '0);
  end

endmodule

>>> sim/prefix_varint_stream_decoder_core_test.sv
`timescale 1ns / 1ps
module prefix_varint_stream_decoder_core_test;
  import pvd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_BYTES  = 170;
  localparam int unsigned PHASE_COUNT  = 10;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned faults;
  int unsigned pending;
  logic        code_open;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned in_calm = 0;
  int unsigned out_calm = 0;
  logic [1:0]  width_now = TWS_RESET;
  logic [1:0]  width_plan [8] = '{WIDTH_64, WIDTH_8, WIDTH_16, WIDTH_32,
                                  WIDTH_64, WIDTH_8, WIDTH_32, WIDTH_16};

  pvd_in_if  in_bus ();
  pvd_out_if out_bus ();
  pvd_cfg_if cfg_bus ();

  prefix_varint_stream_decoder_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  pvd_decode_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_ch    (cfg_bus),
    .faults    (faults),
    .pending   (pending),
    .code_open (code_open)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) calm = $urandom_range(16, 64);
    return $urandom_range(0, 7);
  endfunction

  function automatic logic [7:0] class_lead(input class_t c);
    logic [7:0] l;
    case (c)
      4'd0:    l = 8'h00;
      4'd1:    l = 8'h80;
      4'd2:    l = 8'hc0;
      4'd3:    l = 8'he0;
      4'd4:    l = 8'he8;
      4'd5:    l = 8'hf0;
      4'd6:    l = 8'hf8;
      4'd7:    l = 8'hf9;
      default: l = 8'hfa;
    endcase
    return l;
  endfunction

  function automatic value_t width_limit(input logic [1:0] sel);
    value_t v;
    case (sel)
      WIDTH_8:  v = 64'hff;
      WIDTH_16: v = 64'hffff;
      WIDTH_32: v = 64'hffff_ffff;
      default:  v = '1;
    endcase
    return v;
  endfunction

  // enter and leave at a falling edge; valid stays high for a following word
  task automatic push_byte(input logic [7:0] b);
    int unsigned n;
    n = draw_gap(in_calm);
    if (n > 0) begin
      in_bus.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.in_byte <= b;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic push_code(input class_t c, input logic [127:0] payload);
    len_t         n;
    logic [127:0] head;
    n    = class_bytes(c);
    head = payload >> (8 * (int'(n) - 1));
    push_byte(class_lead(c) | (class_payload_mask(c) & head[7:0]));
    for (int k = int'(n) - 2; k >= 0; k--) push_byte(payload[8*k +: 8]);
  endtask

  task automatic random_code();
    int unsigned  mode;
    class_t       c;
    logic [127:0] p;
    mode = $urandom_range(0, 19);
    if (mode < 2) begin
      push_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (mode == 2) begin
      push_byte(8'($urandom_range(8'hfb, 8'hff)));
      return;
    end
    c = class_t'($urandom_range(0, 8));
    if (mode < 10)
      p = {$urandom, $urandom, $urandom, $urandom};
    else if (mode < 12)
      p = '0;
    else if (mode < 14)
      p = '1;
    else if (mode < 18)
      p = 128'(width_limit(width_now)) + 128'($urandom_range(0, 2)) - 128'd1;
    else
      p = 128'($urandom_range(0, 511));
    push_code(c, p);
  endtask

  // finish any open code, drain, then let the pipeline empty
  task automatic settle();
    while (code_open) push_byte(8'($urandom_range(0, 255)));
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_width(input logic [1:0] sel);
    cfg_bus.valid               <= 1'b1;
    cfg_bus.target_width_select <= sel;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    width_now = sel;
  endtask

  initial begin
    int unsigned n;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      n = draw_gap(out_calm);
      if (n > 0) begin
        out_bus.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
      @(negedge clk);
    end
  end

  initial begin
    int unsigned mark;
    rst_n                       = 1'b0;
    in_bus.valid                = 1'b0;
    in_bus.in_byte              = 8'h00;
    cfg_bus.valid               = 1'b0;
    cfg_bus.target_width_select = TWS_RESET;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_code(4'd0, 128'h0);
    push_code(4'd1, 128'h3fff);
    for (int b = 8'hfb; b <= 8'hff; b++) push_byte(b[7:0]);
    push_code(4'd8, '1);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph > 0) begin
        settle();
        write_width(ph < 8 ? width_plan[ph] : 2'($urandom_range(0, 3)));
      end
      mark = bytes_sent;
      while (bytes_sent - mark < PHASE_BYTES) random_code();
    end
    settle();

    if (faults == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
src/pvd_pkg.sv
src/pvd_if.sv
src/prefix_varint_stream_decoder_core.sv
sim/pvd_decode_checker.sv
sim/prefix_varint_stream_decoder_core_test.sv
